// ===== sv/fmbq_pkg.sv =====
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared sizes, operation and status codes, and the decode-to-cell control
// struct for the front/middle/back queue.
// ----------------------------------------------------------------------------
package fmbq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    // fixed field widths
    localparam int OP_W  = 3;
    localparam int OUT_W = 32;
    localparam int IN_W  = 32;
    localparam int ST_W  = 2;
    localparam int OCC_W = 7;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_MIDDLE = 3'd1,
        OP_PUSH_BACK   = 3'd2,
        OP_POP_FRONT   = 3'd3,
        OP_POP_MIDDLE  = 3'd4,
        OP_POP_BACK    = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic             ins;    // insert word at pos
        logic             rem;    // remove word at pos
        logic             empty;  // pop on an empty queue
        logic [IDX_W-1:0] pos;
        status_t          status;
    } ctl_t;

    // input word into the store width (zero extended or truncated)
    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [IN_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    // stored word onto the result field (low bits, zero extended)
    function automatic logic [OUT_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[OUT_W-1:0];
    endfunction

endpackage

// ===== sv/fmbq_decode.sv =====
// ----------------------------------------------------------------------------
// fmbq_decode
// Turns an operation and the current entry count into an insert/remove
// position and a result status.
// ----------------------------------------------------------------------------
module fmbq_decode (
    input  logic [fmbq_pkg::OP_W-1:0]  op,
    input  logic [fmbq_pkg::CNT_W-1:0] count,
    output fmbq_pkg::ctl_t             ctl
);

    logic                      full;
    logic                      empty;
    logic [fmbq_pkg::IDX_W-1:0] back_pos;
    logic [fmbq_pkg::IDX_W-1:0] last_pos;
    logic [fmbq_pkg::IDX_W-1:0] mid_push;
    logic [fmbq_pkg::IDX_W-1:0] mid_pop;
    logic [fmbq_pkg::CNT_W-1:0] count_m1;

    assign full     = (count >= fmbq_pkg::CNT_W'(fmbq_pkg::DEPTH));
    assign empty    = (count == '0);
    assign count_m1 = count - fmbq_pkg::CNT_W'(1);
    assign back_pos = fmbq_pkg::IDX_W'(count);
    assign last_pos = fmbq_pkg::IDX_W'(count_m1);
    assign mid_push = fmbq_pkg::IDX_W'(count >> 1);
    assign mid_pop  = fmbq_pkg::IDX_W'(count_m1 >> 1);

    always_comb
    begin
        ctl        = '0;
        ctl.status = fmbq_pkg::ST_DONE;
        unique case (op) inside
            fmbq_pkg::OP_PUSH_FRONT,
            fmbq_pkg::OP_PUSH_MIDDLE,
            fmbq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    ctl.status = fmbq_pkg::ST_FULL;
                end
                else
                begin
                    ctl.ins = 1'b1;
                end
                if (op == fmbq_pkg::OP_PUSH_MIDDLE)
                    ctl.pos = mid_push;
                else if (op == fmbq_pkg::OP_PUSH_BACK)
                    ctl.pos = back_pos;
                else
                    ctl.pos = '0;
            end
            fmbq_pkg::OP_POP_FRONT,
            fmbq_pkg::OP_POP_MIDDLE,
            fmbq_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    ctl.empty  = 1'b1;
                    ctl.status = fmbq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctl.rem = 1'b1;
                end
                if (op == fmbq_pkg::OP_POP_MIDDLE)
                    ctl.pos = mid_pop;
                else if (op == fmbq_pkg::OP_POP_BACK)
                    ctl.pos = last_pos;
                else
                    ctl.pos = '0;
            end
            default:
            begin
                ctl = '0;   // unused codes: no change
            end
        endcase
    end

endmodule

// ===== sv/fmbq_cells.sv =====
// ----------------------------------------------------------------------------
// fmbq_cells
// Row of entry cells plus the entry count. On an insert every cell above the
// position shifts up; on a remove every cell from the position shifts down.
// ----------------------------------------------------------------------------
module fmbq_cells (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  fmbq_pkg::ctl_t                  ctl,
    input  logic [fmbq_pkg::DATA_WIDTH-1:0] word,
    output logic [fmbq_pkg::DATA_WIDTH-1:0] sel_word,
    output logic [fmbq_pkg::CNT_W-1:0]      count,
    output logic [fmbq_pkg::CNT_W-1:0]      count_next
);

    logic [fmbq_pkg::DATA_WIDTH-1:0] cell_reg  [fmbq_pkg::DEPTH];
    logic [fmbq_pkg::DATA_WIDTH-1:0] cell_next [fmbq_pkg::DEPTH];
    logic [fmbq_pkg::CNT_W-1:0]      count_reg;

    // one-hot AND-OR read of the selected cell
    always_comb
    begin
        sel_word = '0;
        for (int i = 0; i < fmbq_pkg::DEPTH; i++)
        begin
            if (ctl.pos == fmbq_pkg::IDX_W'(i))
                sel_word = sel_word | cell_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < fmbq_pkg::DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (ctl.ins)
            begin
                if (fmbq_pkg::IDX_W'(i) == ctl.pos)
                    cell_next[i] = word;
                else if ((i > 0) && (fmbq_pkg::IDX_W'(i) > ctl.pos))
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
            end
            else if (ctl.rem)
            begin
                if ((i < fmbq_pkg::DEPTH - 1) && (fmbq_pkg::IDX_W'(i) >= ctl.pos))
                    cell_next[i] = cell_reg[(i < fmbq_pkg::DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
            count_next = count_reg + fmbq_pkg::CNT_W'(1);
        else if (ctl.rem)
            count_next = count_reg - fmbq_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            for (int i = 0; i < fmbq_pkg::DEPTH; i++)
                cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (go)
            count_reg <= count_next;
    end

    assign count = count_reg;

endmodule

// ===== sv/front_middle_back_queue_core.sv =====
// ----------------------------------------------------------------------------
// front_middle_back_queue_core
// Bounded queue of signed words with push and pop at front, middle or back.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid, in_stall, op, value   | into core
//  out     | out_valid, out_stall, popped,   | out of core
//          | status, occupancy               |
//
// One item per cycle sustained while the output is not stalled; an accepted
// item's result passes the input register, then the result register, before
// it is valid and can be taken.
// The whole operation is one pass through the cell row: each cell shifts up,
// shifts down, takes the new word or holds under a compare against the
// decoded position. Reset clears the entry count and valid flags; cell
// contents stay unknown and are never read at or above the count.
// A stalled result holds the input register, which then stalls the input.
// ----------------------------------------------------------------------------
module front_middle_back_queue_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fmbq_pkg::OP_W-1:0]         op,
    input  logic signed [fmbq_pkg::IN_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fmbq_pkg::OUT_W-1:0] popped,
    output logic [fmbq_pkg::ST_W-1:0]         status,
    output logic [fmbq_pkg::OCC_W-1:0]        occupancy
);

    // input register
    logic                         in_vld_reg;
    logic [fmbq_pkg::OP_W-1:0]    op_reg;
    logic [fmbq_pkg::IN_W-1:0]    value_reg;

    // result register
    logic                         out_vld_reg;
    logic [fmbq_pkg::OUT_W-1:0]   popped_reg;
    logic [fmbq_pkg::ST_W-1:0]    status_reg;
    logic [fmbq_pkg::OCC_W-1:0]   occ_reg;

    logic                              go;
    logic                              in_take;
    fmbq_pkg::ctl_t                    ctl;
    logic [fmbq_pkg::DATA_WIDTH-1:0]   sel_word;
    logic [fmbq_pkg::CNT_W-1:0]        count;
    logic [fmbq_pkg::CNT_W-1:0]        count_next;
    logic [fmbq_pkg::OUT_W-1:0]        popped_next;

    // execute when the result slot is free or drains this cycle
    assign go       = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !go;
    assign in_take  = in_valid && !in_stall;

    fmbq_decode u_decode (
        .op    (op_reg),
        .count (count),
        .ctl   (ctl)
    );

    fmbq_cells u_cells (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .ctl        (ctl),
        .word       (fmbq_pkg::to_word(value_reg)),
        .sel_word   (sel_word),
        .count      (count),
        .count_next (count_next)
    );

    always_comb
    begin
        if (ctl.empty)
            popped_next = '1;
        else if (ctl.rem)
            popped_next = fmbq_pkg::to_out(sel_word);
        else
            popped_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (go)
                in_vld_reg <= 1'b0;

            if (go)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (go)
        begin
            popped_reg <= popped_next;
            status_reg <= ctl.status;
            occ_reg    <= fmbq_pkg::OCC_W'(count_next);
        end
    end

    assign out_valid = out_vld_reg;
    assign popped    = $signed(popped_reg);
    assign status    = status_reg;
    assign occupancy = occ_reg;

    // checks
    a_full_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == fmbq_pkg::ST_FULL)
            |-> (occupancy == fmbq_pkg::OCC_W'(fmbq_pkg::DEPTH)))
        else $error("full status with occupancy below depth");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == fmbq_pkg::ST_EMPTY)
            |-> (occupancy == '0) && (popped == -1))
        else $error("empty pop result malformed");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(count))
        else $error("entry count moved without an operation");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_vld_reg && out_stall)
        else $error("input stalled without output back-pressure");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> (count <= fmbq_pkg::CNT_W'(fmbq_pkg::DEPTH))
               && (occupancy == fmbq_pkg::OCC_W'(count)))
        else $error("entry count out of range or result occupancy mismatch");

endmodule

// ===== sim/front_middle_back_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// front_middle_back_queue_core_tb
// Self-checking bench for the front/middle/back queue: a table of directed
// items, then random segments biased to fill, drain or churn the store.
// Every result is checked against a typed expectation or a queue-based predictor.
// ----------------------------------------------------------------------------
module front_middle_back_queue_core_tb;

    // op codes the block leaves unused: they act as no-ops
    localparam logic [fmbq_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [fmbq_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1725;
    localparam int LONG_HOLD    = 300;   // one long receiver hold-off
    localparam int HOLD_AT      = 60;    // result count that triggers it
    localparam int DRAIN_SLACK  = 8;     // cycles after the last result
    localparam int STALL_LIMIT  = 5000;  // cycles with no handshake at all

    typedef struct packed {
        logic [fmbq_pkg::OUT_W-1:0] popped;
        fmbq_pkg::status_t          status;
        logic [fmbq_pkg::OCC_W-1:0] occupancy;
    } result_t;

    typedef struct packed {
        logic [fmbq_pkg::OP_W-1:0] op_code;
        logic [fmbq_pkg::IN_W-1:0] word;
        logic                      typed;    // expected result written in the row
        result_t                   want;
    } stim_row_t;

    // traffic mix of one random segment
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_stall;
    logic [fmbq_pkg::OP_W-1:0]          op        = '0;
    logic signed [fmbq_pkg::IN_W-1:0]   value     = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic signed [fmbq_pkg::OUT_W-1:0]  popped;
    logic [fmbq_pkg::ST_W-1:0]          status;
    logic [fmbq_pkg::OCC_W-1:0]         occupancy;

    // predictor state: words in order from the front
    logic [fmbq_pkg::DATA_WIDTH-1:0] held_words[$];
    // results owed by the block, oldest first
    result_t                         pending_results[$];

    int unsigned error_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned quiet_cycles  = 0;
    bit          no_idle       = 1'b0;   // segment runs with no gaps on either side

    // Directed items. Expected results are typed in only where obvious;
    // the rest lean on the predictor.
    stim_row_t directed_rows [21] = '{
        // pops on an empty queue
        '{fmbq_pkg::OP_POP_FRONT,   32'hdeadbeef, 1'b1,
          '{32'hffffffff, fmbq_pkg::ST_EMPTY, 7'd0}},
        '{fmbq_pkg::OP_POP_MIDDLE,  32'h00000000, 1'b1,
          '{32'hffffffff, fmbq_pkg::ST_EMPTY, 7'd0}},
        '{fmbq_pkg::OP_POP_BACK,    32'hffffffff, 1'b1,
          '{32'hffffffff, fmbq_pkg::ST_EMPTY, 7'd0}},
        // unused op codes do nothing
        '{OP_UNUSED_6,              32'h12345678, 1'b1,
          '{32'h00000000, fmbq_pkg::ST_DONE,  7'd0}},
        '{OP_UNUSED_7,              32'h87654321, 1'b1,
          '{32'h00000000, fmbq_pkg::ST_DONE,  7'd0}},
        // single-entry middle round trip
        '{fmbq_pkg::OP_PUSH_MIDDLE, 32'h7fffffff, 1'b1,
          '{32'h00000000, fmbq_pkg::ST_DONE,  7'd1}},
        '{fmbq_pkg::OP_POP_MIDDLE,  32'h00000000, 1'b1,
          '{32'h7fffffff, fmbq_pkg::ST_DONE,  7'd0}},
        // build up with the extreme words
        '{fmbq_pkg::OP_PUSH_FRONT,  32'h80000000, 1'b1,
          '{32'h00000000, fmbq_pkg::ST_DONE,  7'd1}},
        '{fmbq_pkg::OP_PUSH_BACK,   32'hffffffff, 1'b1,
          '{32'h00000000, fmbq_pkg::ST_DONE,  7'd2}},
        '{fmbq_pkg::OP_PUSH_MIDDLE, 32'h00000000, 1'b1,
          '{32'h00000000, fmbq_pkg::ST_DONE,  7'd3}},
        '{fmbq_pkg::OP_PUSH_MIDDLE, 32'h00000001, 1'b1,
          '{32'h00000000, fmbq_pkg::ST_DONE,  7'd4}},
        '{fmbq_pkg::OP_PUSH_BACK,   32'h55555555, 1'b0, '0},
        '{fmbq_pkg::OP_PUSH_FRONT,  32'haaaaaaaa, 1'b0, '0},
        // middle pops on even then odd counts
        '{fmbq_pkg::OP_POP_MIDDLE,  32'h0f0f0f0f, 1'b0, '0},
        '{fmbq_pkg::OP_POP_MIDDLE,  32'hf0f0f0f0, 1'b0, '0},
        '{fmbq_pkg::OP_POP_BACK,    32'h00000000, 1'b0, '0},
        '{fmbq_pkg::OP_POP_FRONT,   32'h00000000, 1'b0, '0},
        '{OP_UNUSED_6,              32'hffffffff, 1'b0, '0},
        '{fmbq_pkg::OP_POP_MIDDLE,  32'h00000000, 1'b0, '0},
        '{fmbq_pkg::OP_POP_MIDDLE,  32'h00000000, 1'b0, '0},
        // emptied again
        '{fmbq_pkg::OP_POP_BACK,    32'h00000000, 1'b1,
          '{32'hffffffff, fmbq_pkg::ST_EMPTY, 7'd0}}
    };

    front_middle_back_queue_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .popped    (popped),
        .status    (status),
        .occupancy (occupancy)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: applies one operation to held_words and returns the result.
    // Middle push goes in at floor(n/2); middle pop takes floor((n-1)/2).
    // ------------------------------------------------------------------------
    function automatic result_t apply_queue_op(
        input logic [fmbq_pkg::OP_W-1:0] op_code,
        input logic [fmbq_pkg::IN_W-1:0] word);
        result_t                         r;
        logic [fmbq_pkg::DATA_WIDTH-1:0] w;
        int                              n;
        int                              pos;
        r.popped = '0;
        r.status = fmbq_pkg::ST_DONE;
        w        = word;
        n        = held_words.size();
        pos      = 0;
        case (op_code) inside
            fmbq_pkg::OP_PUSH_FRONT, fmbq_pkg::OP_PUSH_MIDDLE, fmbq_pkg::OP_PUSH_BACK:
            begin
                if (n >= fmbq_pkg::DEPTH)
                begin
                    r.status = fmbq_pkg::ST_FULL;   // word dropped
                end
                else
                begin
                    if (op_code == fmbq_pkg::OP_PUSH_MIDDLE)
                        pos = n / 2;
                    else if (op_code == fmbq_pkg::OP_PUSH_BACK)
                        pos = n;
                    held_words.insert(pos, w);
                end
            end
            fmbq_pkg::OP_POP_FRONT, fmbq_pkg::OP_POP_MIDDLE, fmbq_pkg::OP_POP_BACK:
            begin
                if (n == 0)
                begin
                    r.popped = '1;
                    r.status = fmbq_pkg::ST_EMPTY;
                end
                else
                begin
                    if (op_code == fmbq_pkg::OP_POP_MIDDLE)
                        pos = (n - 1) / 2;
                    else if (op_code == fmbq_pkg::OP_POP_BACK)
                        pos = n - 1;
                    r.popped = held_words[pos];
                    held_words.delete(pos);
                end
            end
            default: ;   // unused codes leave the queue alone
        endcase
        r.occupancy = fmbq_pkg::OCC_W'(held_words.size());
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h",
                 results_seen, field, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Sender: optional gap, then hold the item until it is taken. Valid stays
    // high across back-to-back items so it never drops and rises in one step.
    // The prediction is made at the accepting edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [fmbq_pkg::OP_W-1:0] op_code,
                             input logic [fmbq_pkg::IN_W-1:0] word,
                             input logic typed, input result_t want);
        int      gap;
        result_t r;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_code;
        value    <= word;
        do
            @(posedge clk);
        while (in_stall);
        r = apply_queue_op(op_code, word);
        pending_results.insert(pending_results.size(), typed ? want : r);
    endtask

    // drop valid and wait until every owed result is back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall before each result; once, a long hold-off while
    // the sender keeps going, so the core backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int hold;
        int taken;
        taken = 0;
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 9);
            if (taken == HOLD_AT)
                hold = LONG_HOLD;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every accepted result against the oldest expectation.
    // Sampled at the edge, so values are the ones before the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected item", 64'(popped), 64'd0);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (popped !== want.popped)
                    report_mismatch("popped", popped, want.popped);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (occupancy !== want.occupancy)
                    report_mismatch("occupancy", occupancy, want.occupancy);
            end
            results_seen++;
        end
    end

    // Watchdog: any handshake resets the count of idle cycles.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int                        left;
        int                        seg;
        int                        len;
        int                        push_pct;
        mix_t                      mix;
        logic [fmbq_pkg::OP_W-1:0] op_code;
        logic [fmbq_pkg::IN_W-1:0] word;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
            send_item(directed_rows[i].op_code, directed_rows[i].word,
                      directed_rows[i].typed, directed_rows[i].want);
        wait_for_drain();

        // Random segments. The first one always uses the fill mix so pushes on
        // a full queue show up early; later ones pick fill, drain or churn.
        left = RANDOM_ITEMS;
        seg  = 0;
        while (left > 0)
        begin
            if (seg == 0)
                mix = MIX_FILL;
            else
                case ($urandom_range(0, 3))
                    0:       mix = MIX_FILL;
                    1:       mix = MIX_DRAIN;
                    default: mix = MIX_EVEN;
                endcase
            push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
            no_idle  = (seg > 0) && ($urandom_range(0, 3) == 0);
            len      = (seg == 0) ? 110 : $urandom_range(40, 120);
            if (len > left)
                len = left;

            repeat (len)
            begin
                if ($urandom_range(0, 99) < 3)
                    op_code = $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
                else if ($urandom_range(0, 99) < push_pct)
                    case ($urandom_range(0, 2))
                        0:       op_code = fmbq_pkg::OP_PUSH_FRONT;
                        1:       op_code = fmbq_pkg::OP_PUSH_MIDDLE;
                        default: op_code = fmbq_pkg::OP_PUSH_BACK;
                    endcase
                else
                    case ($urandom_range(0, 2))
                        0:       op_code = fmbq_pkg::OP_POP_FRONT;
                        1:       op_code = fmbq_pkg::OP_POP_MIDDLE;
                        default: op_code = fmbq_pkg::OP_POP_BACK;
                    endcase
                // mostly random words, some sign/range extremes
                case ($urandom_range(0, 15))
                    0:       word = 32'h00000000;
                    1:       word = 32'hffffffff;
                    2:       word = 32'h7fffffff;
                    3:       word = 32'h80000000;
                    default: word = $urandom;
                endcase
                send_item(op_code, word, 1'b0, '0);
            end
            left -= len;

            // after the first segment, and after some later ones, the sender pauses until the core has caught up
            if (seg == 0 || $urandom_range(0, 2) == 0)
                wait_for_drain();
            seg++;
        end

        no_idle = 1'b0;
        wait_for_drain();
        repeat (DRAIN_SLACK) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
